[hw/rtl/tleb_pkg.sv]
// ============================================================================
// tleb_pkg: shared constants, codes and types of the line edit buffer
// Sizes of the line store, field widths, mode and status codes, and the job
// descriptor handed from the control stage to the result sequencer.
// ============================================================================
package tleb_pkg;

    // Sizing
    localparam int LINE_BYTES = 128;
    localparam int TAB_WIDTH  = 4;
    localparam int NUM_TERMS  = 3;

    // Port field widths
    localparam int MODE_W   = 2;
    localparam int TERM_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 7;
    localparam int MAXB_W   = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Derived widths
    localparam int LEN_W       = $clog2(LINE_BYTES + 1);
    localparam int STORE_DEPTH = NUM_TERMS * LINE_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TIX_W       = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
    localparam int PHASE_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int MAX_RES     = (TAB_WIDTH > 3) ? TAB_WIDTH : 3;
    localparam int CNT_W       = $clog2(MAX_RES + 1);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_KEY    = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_BEGIN  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_FETCH  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_FINISH = MODE_W'(3);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_FULL   = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_BUSY   = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_NOLINE = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_RANGE  = STATUS_W'(4);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;

    // How the sequencer forms the results of one item
    typedef enum logic [2:0] {
        KIND_PLAIN,     // single result, no echo
        KIND_ERASE,     // backspace, space, backspace
        KIND_TAB,       // run of spaces, each stored
        KIND_CHAR,      // echo and store the key
        KIND_FETCH      // single result carrying a store byte
    } kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        kind_t               kind;
        logic [CNT_W-1:0]    nres;
        logic [CHAR_W-1:0]   echo_char;
        logic [COUNT_W-1:0]  count;
        logic [ADDR_W-1:0]   wr_addr;
    } job_t;

endpackage

[hw/rtl/tleb_ram.sv]
// ============================================================================
// tleb_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and holds while
// no read is issued. Reading an address written in the same cycle returns
// the old contents.
// ============================================================================
module tleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tleb_ctrl.sv]
// ============================================================================
// tleb_ctrl: per-terminal line state and item decode
// Holds length, tab phase, read-active and line-ready for each terminal,
// decodes an accepted item into a job for the sequencer, updates the state
// at accept and issues the store read of a fetch.
// ============================================================================
module tleb_ctrl import tleb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [MODE_W-1:0]  mode,
    input  logic [TERM_W-1:0]  terminal,
    input  logic [CHAR_W-1:0]  key_char,
    input  logic [IDX_W-1:0]   byte_index,
    input  logic [MAXB_W-1:0]  max_bytes,
    output job_t               job,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr
);

    // Per-terminal state; phase tracks length modulo the tab width
    logic [LEN_W-1:0]   len_reg    [NUM_TERMS];
    logic [PHASE_W-1:0] phase_reg  [NUM_TERMS];
    logic               active_reg [NUM_TERMS];
    logic               ready_reg  [NUM_TERMS];

    logic [LEN_W-1:0]   len_next;
    logic [PHASE_W-1:0] phase_next;
    logic               active_next;
    logic               ready_next;

    logic               tvalid;
    logic [TIX_W-1:0]   tsel;
    logic [LEN_W-1:0]   len;
    logic [PHASE_W-1:0] phase;
    logic               act;
    logic               rdy;
    logic [ADDR_W-1:0]  base;
    logic [LEN_W:0]     gap_w;
    logic [LEN_W:0]     room_w;
    logic [LEN_W:0]     tab_n;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_dec;
    logic               full;

    // Selected terminal view and derived quantities
    always_comb
    begin
        tvalid = (32'(terminal) < NUM_TERMS);
        tsel   = tvalid ? TIX_W'(terminal) : '0;
        len    = len_reg[tsel];
        phase  = phase_reg[tsel];
        act    = active_reg[tsel];
        rdy    = ready_reg[tsel];
        base   = ADDR_W'(32'(tsel) * LINE_BYTES);

        // Spaces to the next tab stop, bounded by the slot kept for newline
        gap_w  = (LEN_W+1)'(TAB_WIDTH) - (LEN_W+1)'(phase);
        room_w = (LEN_W+1)'(LINE_BYTES - 1) - {1'b0, len};
        tab_n  = (gap_w < room_w) ? gap_w : room_w;

        phase_sum = (PHASE_W+1)'(phase) + (PHASE_W+1)'(tab_n);
        phase_inc = (32'(phase) == TAB_WIDTH - 1) ? '0 : phase + PHASE_W'(1);
        phase_dec = (phase == '0) ? PHASE_W'(TAB_WIDTH - 1) : phase - PHASE_W'(1);

        full = (32'(len) >= LINE_BYTES) ||
               ((32'(len) == LINE_BYTES - 1) && (key_char != CH_NL));
    end

    // Item decode and next state of the selected terminal
    always_comb
    begin
        job.status    = ST_OK;
        job.kind      = KIND_PLAIN;
        job.nres      = CNT_W'(1);
        job.echo_char = key_char;
        job.count     = '0;
        job.wr_addr   = base + ADDR_W'(len);
        rd_en         = 1'b0;
        rd_addr       = base + ADDR_W'(byte_index);
        len_next      = len;
        phase_next    = phase;
        active_next   = act;
        ready_next    = rdy;

        if (!tvalid)
        begin
            job.status = ST_FULL;
        end
        else
        begin
            case (mode)
                MODE_KEY:
                begin
                    if (key_char == CH_BS)
                    begin
                        // empty line: nothing to erase
                        if (len != '0)
                        begin
                            len_next   = len - LEN_W'(1);
                            phase_next = phase_dec;
                            job.kind   = KIND_ERASE;
                            job.nres   = CNT_W'(3);
                        end
                    end
                    else if (full)
                    begin
                        job.status = ST_FULL;
                    end
                    else if (key_char == CH_TAB)
                    begin
                        job.kind   = KIND_TAB;
                        job.nres   = CNT_W'(tab_n);
                        len_next   = len + LEN_W'(tab_n);
                        phase_next = (32'(phase_sum) == TAB_WIDTH) ? '0
                                                                   : PHASE_W'(phase_sum);
                    end
                    else
                    begin
                        job.kind   = KIND_CHAR;
                        len_next   = len + LEN_W'(1);
                        phase_next = phase_inc;
                        if (key_char == CH_NL)
                        begin
                            ready_next = 1'b1;
                            if (!act)
                            begin
                                len_next   = '0;
                                phase_next = '0;
                            end
                        end
                    end
                end
                MODE_BEGIN:
                begin
                    if (act)
                    begin
                        job.status = ST_BUSY;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        ready_next  = 1'b0;
                    end
                end
                MODE_FETCH:
                begin
                    if (!act || !rdy)
                    begin
                        job.status = ST_NOLINE;
                    end
                    else if ((32'(byte_index) >= 32'(len)) ||
                             (32'(byte_index) >= LINE_BYTES))
                    begin
                        job.status = ST_RANGE;
                    end
                    else
                    begin
                        job.kind = KIND_FETCH;
                        rd_en    = in_fire;
                    end
                end
                MODE_FINISH:
                begin
                    if (!act || !rdy)
                    begin
                        job.status = ST_NOLINE;
                    end
                    else
                    begin
                        job.count   = (32'(max_bytes) < 32'(len)) ? COUNT_W'(max_bytes)
                                                                  : COUNT_W'(len);
                        len_next    = '0;
                        phase_next  = '0;
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    job.status = ST_FULL;
                end
            endcase
        end
    end

    // State update at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                len_reg[i]    <= '0;
                phase_reg[i]  <= '0;
                active_reg[i] <= 1'b0;
                ready_reg[i]  <= 1'b0;
            end
        end
        else if (in_fire && tvalid)
        begin
            len_reg[tsel]    <= len_next;
            phase_reg[tsel]  <= phase_next;
            active_reg[tsel] <= active_next;
            ready_reg[tsel]  <= ready_next;
        end
    end

endmodule

[hw/rtl/tleb_emit.sv]
// ============================================================================
// tleb_emit: result sequencer and output register
// Holds one job, sends its results one per cycle into the output register
// while it is not stalled, writes stored bytes to the line store as their
// echoes go out, and forwards a same-cycle write to a fetch of the same entry.
// ============================================================================
module tleb_emit import tleb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  job_t                job,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [CHAR_W-1:0]   rd_data,
    output logic                in_ready,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [CHAR_W-1:0]   wr_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic                echo_valid,
    output logic [CHAR_W-1:0]   echo_char,
    output logic [CHAR_W-1:0]   read_byte,
    output logic [COUNT_W-1:0]  byte_count,
    output logic                last
);

    // Sequencer registers
    logic               seq_valid_reg;
    logic               seq_valid_next;
    job_t               seq_job_reg;
    logic [CNT_W-1:0]   seq_left_reg;
    logic [ADDR_W-1:0]  seq_addr_reg;
    logic               fwd_hit_reg;
    logic [CHAR_W-1:0]  fwd_data_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                echo_valid_reg;
    logic [CHAR_W-1:0]   echo_char_reg;
    logic [CHAR_W-1:0]   read_byte_reg;
    logic [COUNT_W-1:0]  byte_count_reg;
    logic                last_reg;

    logic                emit;
    logic                seq_last;
    logic                cur_echo_valid;
    logic [CHAR_W-1:0]   cur_echo_char;
    logic [CHAR_W-1:0]   cur_read_byte;

    assign emit     = seq_valid_reg && (!out_valid_reg || out_ready);
    assign seq_last = (seq_left_reg == CNT_W'(1));
    assign in_ready = !seq_valid_reg || (emit && seq_last);

    // Current result beat
    always_comb
    begin
        cur_echo_valid = 1'b0;
        cur_echo_char  = '0;
        cur_read_byte  = '0;
        case (seq_job_reg.kind)
            KIND_ERASE:
            begin
                cur_echo_valid = 1'b1;
                cur_echo_char  = (seq_left_reg == CNT_W'(2)) ? CH_SP : CH_BS;
            end
            KIND_TAB:
            begin
                cur_echo_valid = 1'b1;
                cur_echo_char  = CH_SP;
            end
            KIND_CHAR:
            begin
                cur_echo_valid = 1'b1;
                cur_echo_char  = seq_job_reg.echo_char;
            end
            KIND_FETCH:
            begin
                cur_read_byte = fwd_hit_reg ? fwd_data_reg : rd_data;
            end
            default:
            begin
                cur_echo_valid = 1'b0;
            end
        endcase
    end

    // Store write alongside each stored echo
    assign wr_en   = emit && ((seq_job_reg.kind == KIND_TAB) ||
                              (seq_job_reg.kind == KIND_CHAR));
    assign wr_addr = seq_addr_reg;
    assign wr_data = (seq_job_reg.kind == KIND_TAB) ? CH_SP : seq_job_reg.echo_char;

    always_comb
    begin
        if (in_fire)
        begin
            seq_valid_next = 1'b1;
        end
        else if (emit && seq_last)
        begin
            seq_valid_next = 1'b0;
        end
        else
        begin
            seq_valid_next = seq_valid_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_valid_reg <= seq_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencer payload: load on accept, step on each beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            seq_job_reg  <= job;
            seq_left_reg <= job.nres;
            seq_addr_reg <= job.wr_addr;
        end
        else if (emit)
        begin
            seq_left_reg <= seq_left_reg - CNT_W'(1);
            seq_addr_reg <= seq_addr_reg + ADDR_W'(1);
        end

        // a fetch reading the entry being written this cycle takes the new byte
        if (rd_en)
        begin
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg     <= seq_job_reg.status;
            echo_valid_reg <= cur_echo_valid;
            echo_char_reg  <= cur_echo_char;
            read_byte_reg  <= cur_read_byte;
            byte_count_reg <= seq_job_reg.count;
            last_reg       <= seq_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign echo_valid = echo_valid_reg;
    assign echo_char  = echo_char_reg;
    assign read_byte  = read_byte_reg;
    assign byte_count = byte_count_reg;
    assign last       = last_reg;

endmodule

[hw/rtl/terminal_line_edit_buffer_unit.sv]
// ============================================================================
// terminal_line_edit_buffer_unit: canonical line editor, one line per terminal
// An item is held in the sequencer; its results go out via the output register.
// Throughput: one result beat per cycle while the output is not stalled; an
// item gives n results (n = 1, 3 for backspace, up to the tab width for a tab),
// and the next item is taken in the cycle its predecessor's last beat moves.
// Reset clears line length, tab phase, read and ready flags of every terminal
// at once; the line store is not cleared and needs no clearing pass.
// ============================================================================
module terminal_line_edit_buffer_unit import tleb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TERM_W-1:0]   terminal,
    input  logic [CHAR_W-1:0]   key_char,
    input  logic [IDX_W-1:0]    byte_index,
    input  logic [MAXB_W-1:0]   max_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                echo_valid,
    output logic [CHAR_W-1:0]   echo_char,
    output logic [CHAR_W-1:0]   read_byte,
    output logic [COUNT_W-1:0]  byte_count,
    output logic                last
);

    logic              in_fire;
    job_t              job;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;

    assign in_fire = in_valid && in_ready;

    // Per-terminal state and decode
    tleb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .mode       (mode),
        .terminal   (terminal),
        .key_char   (key_char),
        .byte_index (byte_index),
        .max_bytes  (max_bytes),
        .job        (job),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    // Line store, all terminals back to back
    tleb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result sequencing and output register
    tleb_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .job        (job),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .in_ready   (in_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .echo_valid (echo_valid),
        .echo_char  (echo_char),
        .read_byte  (read_byte),
        .byte_count (byte_count),
        .last       (last)
    );

endmodule

[hw/rtl/tleb_checker.sv]
// ============================================================================
// tleb_checker: port-level checks of the line edit buffer
// Watches the result channel for held beats, consistent status and payload,
// and back-to-back beats within one item.
// ============================================================================
module tleb_checker import tleb_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic                echo_valid,
    input logic [CHAR_W-1:0]   echo_char,
    input logic [CHAR_W-1:0]   read_byte,
    input logic [COUNT_W-1:0]  byte_count,
    input logic                last
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
                                    $stable(echo_char) && $stable(last))
        else $error("result beat changed while stalled");

    // Echo only on successful keys
    a_echo_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && echo_valid |-> status == ST_OK)
        else $error("echo with error status");

    // An error is a single bare beat
    a_err_bare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> last && !echo_valid &&
                                          (read_byte == '0) && (byte_count == '0))
        else $error("error beat carries payload or is not last");

    // Beats of one item follow each other without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside an item's results");

    // Handed-over count never exceeds a line
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(byte_count) <= LINE_BYTES)
        else $error("byte count beyond line size");

endmodule

bind terminal_line_edit_buffer_unit tleb_checker u_tleb_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for terminal_line_edit_buffer_unit
// Drives keystroke and read items through the input channel and checks every
// result beat against a line-discipline predictor kept in step with the
// accepted items. Directed edit and read sequences come first, then random
// sessions, full lines and a long receiver hold-off, under three idling mixes.
// ----------------------------------------------------------------------------
module tb;
    import tleb_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no beat moving
    localparam int LONG_HOLD   = 200;    // receiver hold-off in pressure test
    localparam int TAIL_CYCLES = 10;

    // One expected result beat
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                echo_valid;
        logic [CHAR_W-1:0]   echo_char;
        logic [CHAR_W-1:0]   read_byte;
        logic [COUNT_W-1:0]  byte_count;
        logic                last;
    } beat_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode       = MODE_KEY;
    logic [TERM_W-1:0]   terminal   = '0;
    logic [CHAR_W-1:0]   key_char   = '0;
    logic [IDX_W-1:0]    byte_index = '0;
    logic [MAXB_W-1:0]   max_bytes  = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                echo_valid;
    logic [CHAR_W-1:0]   echo_char;
    logic [CHAR_W-1:0]   read_byte;
    logic [COUNT_W-1:0]  byte_count;
    logic                last;

    // Predicted terminal state
    logic [CHAR_W-1:0] line_buf [NUM_TERMS][LINE_BYTES];
    int                line_len [NUM_TERMS];
    bit                reading  [NUM_TERMS];
    bit                line_done[NUM_TERMS];

    beat_t due_beats[$];
    int    mismatch_count = 0;
    int    items_sent     = 0;
    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;
    int    quiet_cycles   = 0;
    int    hold_left      = 0;
    bit    hold_request   = 1'b0;

    terminal_line_edit_buffer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .terminal   (terminal),
        .key_char   (key_char),
        .byte_index (byte_index),
        .max_bytes  (max_bytes),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .echo_valid (echo_valid),
        .echo_char  (echo_char),
        .read_byte  (read_byte),
        .byte_count (byte_count),
        .last       (last)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void owe_beat(input logic [STATUS_W-1:0] st, input logic ev,
                                     input logic [CHAR_W-1:0] ec,
                                     input logic [CHAR_W-1:0] rb,
                                     input logic [COUNT_W-1:0] bc, input logic lst);
        beat_t b;
        b.status     = st;
        b.echo_valid = ev;
        b.echo_char  = ec;
        b.read_byte  = rb;
        b.byte_count = bc;
        b.last       = lst;
        due_beats.push_back(b);
    endfunction

    function automatic void predict_line_edit(input logic [MODE_W-1:0] m,
                                              input logic [TERM_W-1:0] t,
                                              input logic [CHAR_W-1:0] c,
                                              input logic [IDX_W-1:0] ix,
                                              input logic [MAXB_W-1:0] mb);
        int ti;
        int len;
        int cnt;
        bit stop;
        ti = t;
        if (ti >= NUM_TERMS) begin
            owe_beat(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
        end else begin
            len = line_len[ti];
            case (m)
                MODE_KEY: begin
                    if (c == CH_BS) begin
                        // erase: nothing on an empty line
                        if (len == 0) begin
                            owe_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
                        end else begin
                            len = len - 1;
                            owe_beat(ST_OK, 1'b1, CH_BS, '0, '0, 1'b0);
                            owe_beat(ST_OK, 1'b1, CH_SP, '0, '0, 1'b0);
                            owe_beat(ST_OK, 1'b1, CH_BS, '0, '0, 1'b1);
                        end
                    end else if (len >= LINE_BYTES || (len == LINE_BYTES - 1 && c != CH_NL)) begin
                        // last slot is reserved for newline
                        owe_beat(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                    end else if (c == CH_TAB) begin
                        // spaces up to the next tab stop or the reserved slot
                        stop = 1'b0;
                        for (int i = 0; i < TAB_WIDTH && !stop; i++) begin
                            line_buf[ti][len] = CH_SP;
                            len = len + 1;
                            stop = (len == LINE_BYTES - 1) || (len % TAB_WIDTH == 0) ||
                                   (i == TAB_WIDTH - 1);
                            owe_beat(ST_OK, 1'b1, CH_SP, '0, '0, stop);
                        end
                    end else begin
                        line_buf[ti][len] = c;
                        len = len + 1;
                        owe_beat(ST_OK, 1'b1, c, '0, '0, 1'b1);
                        if (c == CH_NL) begin
                            line_done[ti] = 1'b1;
                            if (!reading[ti])
                                len = 0;
                        end
                    end
                    line_len[ti] = len;
                end
                MODE_BEGIN: begin
                    if (reading[ti]) begin
                        owe_beat(ST_BUSY, 1'b0, '0, '0, '0, 1'b1);
                    end else begin
                        reading[ti]   = 1'b1;
                        line_done[ti] = 1'b0;
                        owe_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
                    end
                end
                default: begin
                    if (!reading[ti] || !line_done[ti]) begin
                        owe_beat(ST_NOLINE, 1'b0, '0, '0, '0, 1'b1);
                    end else if (m == MODE_FETCH) begin
                        if (int'(ix) >= len)
                            owe_beat(ST_RANGE, 1'b0, '0, '0, '0, 1'b1);
                        else
                            owe_beat(ST_OK, 1'b0, '0, line_buf[ti][ix], '0, 1'b1);
                    end else begin
                        cnt = len;
                        if (int'(mb) < cnt)
                            cnt = mb;
                        line_len[ti] = 0;
                        reading[ti]  = 1'b0;
                        owe_beat(ST_OK, 1'b0, '0, '0, COUNT_W'(cnt), 1'b1);
                    end
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk) begin
        beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (due_beats.size() == 0) begin
                report_mismatch("result beat with no item pending");
            end else begin
                want = due_beats.pop_front();
                check_field("status", 32'(status), 32'(want.status));
                check_field("echo_valid", 32'(echo_valid), 32'(want.echo_valid));
                check_field("echo_char", 32'(echo_char), 32'(want.echo_char));
                check_field("read_byte", 32'(read_byte), 32'(want.read_byte));
                check_field("byte_count", 32'(byte_count), 32'(want.byte_count));
                check_field("last", 32'(last), 32'(want.last));
            end
        end
    end

    // Receiver: random stalls, or one long hold-off on request
    always @(posedge clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: nothing moving on either channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [TERM_W-1:0] t,
                             input logic [CHAR_W-1:0] c, input logic [IDX_W-1:0] ix,
                             input logic [MAXB_W-1:0] mb);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        terminal   <= t;
        key_char   <= c;
        byte_index <= ix;
        max_bytes  <= mb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_line_edit(m, t, c, ix, mb);
        items_sent++;
    endtask

    // unused fields carry random junk
    task automatic send_key(input logic [TERM_W-1:0] t, input logic [CHAR_W-1:0] c);
        send_item(MODE_KEY, t, c, IDX_W'($urandom), MAXB_W'($urandom));
    endtask

    task automatic send_read(input logic [MODE_W-1:0] m, input logic [TERM_W-1:0] t,
                             input logic [IDX_W-1:0] ix, input logic [MAXB_W-1:0] mb);
        send_item(m, t, CHAR_W'($urandom), ix, mb);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            pick_key = CH_BS;
        else if (r < 30)
            pick_key = CH_TAB;
        else if (r < 34)
            pick_key = CH_NL;
        else
            pick_key = CHAR_W'($urandom);
    endfunction

    // Editing: plain keys, erase, tab stops, newline, bad terminal
    task automatic test_edit_keys();
        send_key(0, 8'h61);                 // 'a'
        send_key(0, CH_BS);
        send_key(0, CH_BS);                 // erase on empty line
        send_key(0, CH_TAB);                // full tab stop
        send_key(0, 8'hFF);
        send_key(0, CH_TAB);                // partial tab stop
        send_key(0, 8'h00);
        send_key(0, CH_NL);                 // no reader: line cleared
        send_key(TERM_W'(NUM_TERMS), 8'h41);
        send_read(MODE_BEGIN, TERM_W'(NUM_TERMS), '0, '0);
    endtask

    // Read protocol: begin, busy, not ready, fetch, range, finish
    task automatic test_read_handshake();
        send_read(MODE_BEGIN, 1, IDX_W'($urandom), MAXB_W'($urandom));
        send_read(MODE_BEGIN, 1, IDX_W'($urandom), MAXB_W'($urandom));
        send_read(MODE_FETCH, 1, '0, MAXB_W'($urandom));
        send_key(1, 8'h78);
        send_key(1, CH_TAB);
        send_key(1, CH_NL);                 // reader active: line kept
        send_read(MODE_FETCH, 1, '0, MAXB_W'($urandom));
        send_read(MODE_FETCH, 1, 4, MAXB_W'($urandom));
        send_read(MODE_FETCH, 1, 5, MAXB_W'($urandom));
        send_read(MODE_FINISH, 1, IDX_W'($urandom), 3);
        send_read(MODE_FINISH, 1, IDX_W'($urandom), '1);
        send_read(MODE_BEGIN, 0, IDX_W'($urandom), MAXB_W'($urandom));
        send_read(MODE_FETCH, 0, '0, MAXB_W'($urandom));
    endtask

    // Fill a line to the reserved slot, then probe the full cases
    task automatic test_full_line(input bit with_read);
        logic [TERM_W-1:0] t;
        t = TERM_W'($urandom_range(NUM_TERMS - 1));
        if (with_read)
            send_read(MODE_BEGIN, t, IDX_W'($urandom), MAXB_W'($urandom));
        while (line_len[t] < LINE_BYTES - 1)
            send_key(t, ($urandom_range(99) < 85) ? CH_TAB : CHAR_W'($urandom_range(32, 255)));
        send_key(t, CHAR_W'($urandom_range(32, 126)));
        send_key(t, CH_TAB);
        send_key(t, CH_BS);
        send_key(t, CHAR_W'($urandom_range(32, 126)));
        send_key(t, CH_NL);
        send_key(t, CH_NL);
        send_read(MODE_FETCH, t, IDX_W'(LINE_BYTES - 1), MAXB_W'($urandom));
        send_read(MODE_FINISH, t, IDX_W'($urandom), '1);
    endtask

    // Receiver holds off while the sender keeps offering multi-beat keys
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (16)
            send_key(TERM_W'($urandom_range(NUM_TERMS - 1)),
                     $urandom_range(1) ? CH_TAB : CH_BS);
        wait_results_drained();
    endtask

    // Random sessions: begin, typing, newline, fetches, finish; some noise
    task automatic test_random_sessions(input int budget);
        int start;
        int cur;
        logic [TERM_W-1:0] t;
        bit with_read;
        start = items_sent;
        while (items_sent - start < budget) begin
            t = ($urandom_range(9) == 0) ? TERM_W'(NUM_TERMS)
                                         : TERM_W'($urandom_range(NUM_TERMS - 1));
            if ($urandom_range(99) < 15) begin
                send_item(MODE_W'($urandom), TERM_W'($urandom), CHAR_W'($urandom),
                          IDX_W'($urandom), MAXB_W'($urandom));
            end else begin
                with_read = ($urandom_range(99) < 70);
                if (with_read)
                    send_read(MODE_BEGIN, t, IDX_W'($urandom), MAXB_W'($urandom));
                repeat ($urandom_range(1, 10))
                    send_key(t, pick_key());
                if ($urandom_range(99) < 80)
                    send_key(t, CH_NL);
                if (with_read) begin
                    cur = (t < NUM_TERMS) ? line_len[t] : 0;
                    repeat ($urandom_range(0, 3))
                        send_read(MODE_FETCH, t,
                                  (cur > 0 && $urandom_range(99) < 75)
                                      ? IDX_W'($urandom_range(cur - 1)) : IDX_W'($urandom),
                                  MAXB_W'($urandom));
                    if ($urandom_range(9) == 0)
                        send_read(MODE_BEGIN, t, IDX_W'($urandom), MAXB_W'($urandom));
                    send_read(MODE_FINISH, t, IDX_W'($urandom),
                              $urandom_range(1) ? MAXB_W'($urandom)
                                                : MAXB_W'($urandom_range(cur + 2)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 24;
        recv_idle_pct = 53;
        test_edit_keys();
        test_read_handshake();
        wait_results_drained();
        test_random_sessions(25);
        test_full_line(1'b1);
        wait_results_drained();

        // the other way round
        send_idle_pct = 53;
        recv_idle_pct = 24;
        test_backpressure();
        test_random_sessions(25);
        wait_results_drained();

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_line(1'b0);
        test_random_sessions(25);
        wait_results_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tleb_pkg.sv
hw/rtl/tleb_ram.sv
hw/rtl/tleb_ctrl.sv
hw/rtl/tleb_emit.sv
hw/rtl/terminal_line_edit_buffer_unit.sv
hw/rtl/tleb_checker.sv
test/tb.sv
